>>> rtl/core/pmc_pkg.sv
// pmc_pkg: shared types, constants and helpers of the pwm led controller
`default_nettype none

package pmc_pkg;

  localparam int CHANNELS = 16;
  localparam int ChIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    CMD_SET_PTR = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_READ    = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_SRESET  = 3'd4
  } cmd_e;

  localparam logic [7:0] AddrMode1    = 8'h00;
  localparam logic [7:0] AddrMode2    = 8'h01;
  localparam logic [7:0] AddrBusFirst = 8'h02;
  localparam logic [7:0] AddrBusLast  = 8'h05;
  localparam logic [7:0] AddrLedFirst = 8'h06;
  localparam logic [7:0] AddrAllFirst = 8'hFA;
  localparam logic [7:0] AddrAllLast  = 8'hFD;
  localparam logic [7:0] AddrPrescale = 8'hFE;

  localparam int BitAi    = 5;
  localparam int BitSleep = 4;
  localparam int BitFull  = 4;

  localparam logic [7:0] PrescaleMin   = 8'h03;
  localparam logic [7:0] Mode1Reset    = 8'h11;
  localparam logic [7:0] Mode2Reset    = 8'h04;
  localparam logic [7:0] PrescaleReset = 8'h1E;
  localparam logic [7:0] OffHighReset  = 8'h10;

  localparam logic [1:0] ByteOnL  = 2'd0;
  localparam logic [1:0] ByteOnH  = 2'd1;
  localparam logic [1:0] ByteOffL = 2'd2;
  localparam logic [1:0] ByteOffH = 2'd3;

  typedef struct packed {
    logic [7:0] on_l;
    logic [7:0] on_h;
    logic [7:0] off_l;
    logic [7:0] off_h;
  } chan_t;

  typedef chan_t [CHANNELS-1:0] chan_arr_t;

  // one item as seen by the state-holding units
  typedef struct packed {
    logic       fire;
    cmd_e       cmd;
    logic [7:0] addr;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic       sleep;
    logic [7:0] prescale;
  } time_cfg_t;

  function automatic chan_t chan_reset();
    chan_t c;
    c.on_l  = 8'h00;
    c.on_h  = 8'h00;
    c.off_l = 8'h00;
    c.off_h = OffHighReset;
    return c;
  endfunction

  function automatic logic [7:0] chan_get(chan_t c, logic [1:0] sel);
    logic [7:0] v;
    unique case (sel)
      ByteOnL:  v = c.on_l;
      ByteOnH:  v = c.on_h;
      ByteOffL: v = c.off_l;
      default:  v = c.off_h;
    endcase
    return v;
  endfunction

  function automatic chan_t chan_set(chan_t c, logic [1:0] sel, logic [7:0] v);
    chan_t r;
    r = c;
    unique case (sel)
      ByteOnL:  r.on_l  = v;
      ByteOnH:  r.on_h  = v;
      ByteOffL: r.off_l = v;
      default:  r.off_h = v;
    endcase
    return r;
  endfunction

  function automatic logic chan_level(chan_t c, logic [11:0] cnt);
    logic [11:0] on_t;
    logic [11:0] off_t;
    logic        lvl;
    on_t  = {c.on_h[3:0], c.on_l};
    off_t = {c.off_h[3:0], c.off_l};
    if (c.off_h[BitFull]) begin
      lvl = 1'b0;
    end else if (c.on_h[BitFull]) begin
      lvl = 1'b1;
    end else if (on_t < off_t) begin
      lvl = (cnt >= on_t) && (cnt < off_t);
    end else if (on_t > off_t) begin
      lvl = (cnt >= on_t) || (cnt < off_t);
    end else begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pmc_regfile.sv
// pmc_regfile: byte register map, register pointer and read/write decode
`default_nettype none

module pmc_regfile (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  pmc_pkg::op_t           op_i,
  output logic [7:0]             rd_data_o,
  output logic                   blocked_o,
  output pmc_pkg::time_cfg_t     time_cfg_o,
  output pmc_pkg::chan_arr_t     chans_o
);

  pmc_pkg::chan_arr_t chans_q, chans_d;
  logic [7:0] mode1_q, mode1_d;
  logic [7:0] mode2_q, mode2_d;
  logic [7:0] prescale_q, prescale_d;
  logic [7:0] bus_q [4];
  logic [7:0] bus_d [4];
  logic [7:0] ptr_q, ptr_d;

  logic [7:0]                  led_off;
  logic                        is_led;
  logic [pmc_pkg::ChIdxW-1:0]  led_ch;
  logic [1:0]                  led_byte;
  logic [7:0]                  bus_off;
  logic [7:0]                  all_off;
  logic                        is_bus;
  logic                        is_all;

  // address decode at the pointer
  always_comb begin
    led_off  = ptr_q - pmc_pkg::AddrLedFirst;
    is_led   = (ptr_q >= pmc_pkg::AddrLedFirst) && (led_off < 8'd64) &&
               ({4'd0, led_off[5:2]} < 8'(pmc_pkg::CHANNELS));
    led_ch   = led_off[pmc_pkg::ChIdxW+1:2];
    led_byte = led_off[1:0];
    bus_off  = ptr_q - pmc_pkg::AddrBusFirst;
    all_off  = ptr_q - pmc_pkg::AddrAllFirst;
    is_bus   = (ptr_q >= pmc_pkg::AddrBusFirst) && (ptr_q <= pmc_pkg::AddrBusLast);
    is_all   = (ptr_q >= pmc_pkg::AddrAllFirst) && (ptr_q <= pmc_pkg::AddrAllLast);
  end

  always_comb begin
    chans_d    = chans_q;
    mode1_d    = mode1_q;
    mode2_d    = mode2_q;
    prescale_d = prescale_q;
    bus_d      = bus_q;
    ptr_d      = ptr_q;
    rd_data_o  = 8'h00;
    blocked_o  = 1'b0;
    if (op_i.fire) begin
      unique case (op_i.cmd)
        pmc_pkg::CMD_SET_PTR: begin
          ptr_d = op_i.addr;
        end
        pmc_pkg::CMD_WRITE: begin
          priority if (ptr_q == pmc_pkg::AddrMode1) begin
            mode1_d = op_i.data;
          end else if (ptr_q == pmc_pkg::AddrMode2) begin
            mode2_d = op_i.data;
          end else if (is_bus) begin
            bus_d[bus_off[1:0]] = op_i.data;
          end else if (ptr_q == pmc_pkg::AddrPrescale) begin
            if (!mode1_q[pmc_pkg::BitSleep]) begin
              blocked_o = 1'b1;
            end else begin
              prescale_d = (op_i.data < pmc_pkg::PrescaleMin) ?
                           pmc_pkg::PrescaleMin : op_i.data;
            end
          end else if (is_all) begin
            for (int i = 0; i < pmc_pkg::CHANNELS; i++) begin
              chans_d[i] = pmc_pkg::chan_set(chans_q[i], all_off[1:0], op_i.data);
            end
          end else if (is_led) begin
            chans_d[led_ch] = pmc_pkg::chan_set(chans_q[led_ch], led_byte, op_i.data);
          end else begin
            // reserved: ignored
          end
          // a write to mode1 decides the increment with its new ai bit
          if (mode1_d[pmc_pkg::BitAi]) ptr_d = ptr_q + 8'd1;
        end
        pmc_pkg::CMD_READ: begin
          priority if (ptr_q == pmc_pkg::AddrMode1) begin
            rd_data_o = mode1_q;
          end else if (ptr_q == pmc_pkg::AddrMode2) begin
            rd_data_o = mode2_q;
          end else if (is_bus) begin
            rd_data_o = bus_q[bus_off[1:0]];
          end else if (ptr_q == pmc_pkg::AddrPrescale) begin
            rd_data_o = prescale_q;
          end else if (is_led) begin
            rd_data_o = pmc_pkg::chan_get(chans_q[led_ch], led_byte);
          end else begin
            rd_data_o = 8'h00;
          end
          if (mode1_q[pmc_pkg::BitAi]) ptr_d = ptr_q + 8'd1;
        end
        pmc_pkg::CMD_SRESET: begin
          for (int i = 0; i < pmc_pkg::CHANNELS; i++) begin
            chans_d[i] = pmc_pkg::chan_reset();
          end
          mode1_d    = pmc_pkg::Mode1Reset;
          mode2_d    = pmc_pkg::Mode2Reset;
          prescale_d = pmc_pkg::PrescaleReset;
          bus_d[0]   = 8'hE2;
          bus_d[1]   = 8'hE4;
          bus_d[2]   = 8'hE8;
          bus_d[3]   = 8'hE0;
          ptr_d      = 8'h00;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pmc_pkg::CHANNELS; i++) begin
        chans_q[i] <= pmc_pkg::chan_reset();
      end
      mode1_q    <= pmc_pkg::Mode1Reset;
      mode2_q    <= pmc_pkg::Mode2Reset;
      prescale_q <= pmc_pkg::PrescaleReset;
      bus_q[0]   <= 8'hE2;
      bus_q[1]   <= 8'hE4;
      bus_q[2]   <= 8'hE8;
      bus_q[3]   <= 8'hE0;
      ptr_q      <= 8'h00;
    end else begin
      chans_q    <= chans_d;
      mode1_q    <= mode1_d;
      mode2_q    <= mode2_d;
      prescale_q <= prescale_d;
      bus_q      <= bus_d;
      ptr_q      <= ptr_d;
    end
  end

  assign chans_o             = chans_q;
  assign time_cfg_o.sleep    = mode1_q[pmc_pkg::BitSleep];
  assign time_cfg_o.prescale = prescale_q;

`ifndef SYNTHESIS
  a_prescale_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prescale_q >= pmc_pkg::PrescaleMin)
    else $error("prescale below minimum");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pmc_timebase.sv
// pmc_timebase: oscillator prescaler and 12-bit pwm counter
`default_nettype none

module pmc_timebase (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  pmc_pkg::op_t       op_i,
  input  pmc_pkg::time_cfg_t time_cfg_i,
  output logic [11:0]        count_o
);

  logic [7:0]  pre_q, pre_d;
  logic [11:0] count_q, count_d;

  always_comb begin
    pre_d   = pre_q;
    count_d = count_q;
    if (op_i.fire) begin
      unique case (op_i.cmd)
        pmc_pkg::CMD_TICK: begin
          if (!time_cfg_i.sleep) begin
            if (pre_q == time_cfg_i.prescale) begin
              pre_d   = 8'h00;
              count_d = count_q + 12'd1;
            end else begin
              pre_d = pre_q + 8'd1;
            end
          end
        end
        pmc_pkg::CMD_SRESET: begin
          pre_d   = 8'h00;
          count_d = 12'h000;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= 8'h00;
      count_q <= 12'h000;
    end else begin
      pre_q   <= pre_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

`ifndef SYNTHESIS
  // the counter is frozen while asleep
  a_sleep_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.fire && op_i.cmd == pmc_pkg::CMD_TICK && time_cfg_i.sleep)
      |=> $stable(count_q) && $stable(pre_q))
    else $error("counter moved during sleep");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pmc_channels.sv
// pmc_channels: per-channel on/off compare against the pwm counter
`default_nettype none

module pmc_channels (
  input  pmc_pkg::chan_arr_t chans_i,
  input  wire logic [11:0]   count_i,
  output logic [15:0]        levels_o
);

  always_comb begin
    levels_o = 16'h0000;
    for (int i = 0; i < pmc_pkg::CHANNELS; i++) begin
      levels_o[i] = pmc_pkg::chan_level(chans_i[i], count_i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pwm_led_controller_16ch.sv
// pwm_led_controller_16ch: top level with input and result registers
// Usage:
//   in channel (in_valid_i / in_stall_o) carries one command per item:
//   set pointer, write byte, read byte, oscillator tick or software reset.
//   out channel (out_valid_o / out_stall_i) returns one result per item:
//   the byte read, the channel levels after the item and the blocked flag.
// Timing: an item waits in the input register until it fires; at that edge it is
//   applied to the register map and timebase and its result is loaded into the
//   result register, from which it is shown.
// Throughput: one item per cycle while out_stall_i is low; each item is a single
//   pass through the register map decode and the 16 parallel channel compares.
// pwm_levels_o follows the state registers, which only change when the
//   result register takes a new item, so it stays fixed with its result.
// Reset: rst_ni clears both pipeline registers and loads every register of
//   the map with its power-on value; the software reset command does the same
//   to the map, pointer and counters.
// Stall: while out_stall_i holds a waiting result, the item in the input
//   register waits and in_stall_o rises; nothing is lost or repeated.
`default_nettype none

module pwm_led_controller_16ch (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic [15:0]      pwm_levels_o,
  output logic             write_blocked_o
);

  logic       in_valid_q;
  logic [2:0] cmd_q;
  logic [7:0] addr_q;
  logic [7:0] data_q;
  logic       out_valid_q;
  logic [7:0] rd_q;
  logic       blk_q;
  logic       fire;
  logic       in_take;

  pmc_pkg::op_t       op;
  pmc_pkg::time_cfg_t time_cfg;
  pmc_pkg::chan_arr_t chans;
  logic [11:0]        count;
  logic [7:0]         rd_data;
  logic               blocked;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  assign op.fire = fire;
  assign op.cmd  = pmc_pkg::cmd_e'(cmd_q);
  assign op.addr = addr_q;
  assign op.data = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (fire) begin
      rd_q  <= rd_data;
      blk_q <= blocked;
    end
  end

  pmc_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .rd_data_o  (rd_data),
    .blocked_o  (blocked),
    .time_cfg_o (time_cfg),
    .chans_o    (chans)
  );

  pmc_timebase u_timebase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .time_cfg_i (time_cfg),
    .count_o    (count)
  );

  pmc_channels u_channels (
    .chans_i  (chans),
    .count_i  (count),
    .levels_o (pwm_levels_o)
  );

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_q;
  assign write_blocked_o = blk_q;

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("result overwritten while stalled");

  // a refused prescale write never also returns read data
  a_blocked_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && blk_q) |-> (rd_q == 8'h00))
    else $error("blocked write carries read data");

  // an item is taken only into an empty or draining input register
  a_in_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted item lost in input register");
`endif

endmodule

`default_nettype wire
